// ===== rtl/core/rtc_calendar_counter_macros.svh =====
// assertion macros for the rtc calendar counter checker
`ifndef RTC_CALENDAR_COUNTER_MACROS_SVH
`define RTC_CALENDAR_COUNTER_MACROS_SVH

// property that must hold in the same cycle as its trigger
`define RTCC_ASSERT_IMP(lbl, ant, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |-> (cons)) \
    else $error("rtcc assertion failed: same-cycle implication");

// property that must hold in the cycle after its trigger
`define RTCC_ASSERT_NXT(lbl, ant, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |=> (cons)) \
    else $error("rtcc assertion failed: next-cycle implication");

`endif

// ===== rtl/core/rtcc_pkg.sv =====
// shared types, constants and month table for the rtc calendar counter
package rtcc_pkg;

  localparam logic [7:0]  TPS_RESET      = 8'd20;
  localparam logic [5:0]  SEC_LAST       = 6'd59;
  localparam logic [5:0]  MIN_LAST       = 6'd59;
  localparam logic [4:0]  HOUR_LAST      = 5'd23;
  localparam logic [3:0]  MONTH_FEB      = 4'd2;
  localparam logic [3:0]  MONTH_DEC      = 4'd12;
  localparam logic [13:0] YEAR_MAX       = 14'd9999;
  localparam logic [6:0]  MOD100_LAST    = 7'd99;
  localparam logic [8:0]  MOD400_LAST    = 9'd399;
  localparam logic [2:0]  WEEK_LAST      = 3'd7;
  localparam logic [4:0]  LEAP_FEB_DAYS  = 5'd29;

  localparam logic [4:0] MONTH_LEN [16] = '{
    5'd31, 5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31,
    5'd31, 5'd30, 5'd31, 5'd30, 5'd31, 5'd31, 5'd31, 5'd31
  };

  typedef struct packed {
    logic [7:0]  prescale;
    logic [5:0]  sec;
    logic [5:0]  min;
    logic [4:0]  hour;
    logic [4:0]  day;
    logic [3:0]  month;
    logic [13:0] year;
    logic [6:0]  year_mod100;
    logic [8:0]  year_mod400;
    logic [2:0]  week;
    logic        date_pending;
  } rtcc_state_t;

  localparam rtcc_state_t STATE_RESET = '{
    prescale:     8'd0,
    sec:          6'd0,
    min:          6'd30,
    hour:         5'd12,
    day:          5'd29,
    month:        4'd3,
    year:         14'd2026,
    year_mod100:  7'd26,
    year_mod400:  9'd26,
    week:         3'd7,
    date_pending: 1'b1
  };

  typedef struct packed {
    logic [5:0]  seconds;
    logic [5:0]  minutes;
    logic [4:0]  hours;
    logic [4:0]  day_of_month;
    logic [3:0]  month_number;
    logic [13:0] year_number;
    logic [2:0]  weekday;
    logic        time_changed;
    logic        date_changed;
  } rtcc_result_t;

  function automatic logic [4:0] month_days(input logic [3:0] month, input logic leap);
    logic [4:0] days;
    days = MONTH_LEN[month];
    if (leap && (month == MONTH_FEB)) begin
      days = LEAP_FEB_DAYS;
    end
    return days;
  endfunction

endpackage

// ===== rtl/core/rtcc_if.sv =====
// request channels of the rtc calendar counter
interface rtcc_in_if;
  logic valid;
  logic ready;
  logic tick;
  modport source (output valid, output tick, input ready);
  modport sink (input valid, input tick, output ready);
endinterface

interface rtcc_out_if;
  logic        valid;
  logic        ready;
  logic [5:0]  seconds;
  logic [5:0]  minutes;
  logic [4:0]  hours;
  logic [4:0]  day_of_month;
  logic [3:0]  month_number;
  logic [13:0] year_number;
  logic [2:0]  weekday;
  logic        time_changed;
  logic        date_changed;
  modport source (output valid, output seconds, output minutes, output hours,
                  output day_of_month, output month_number, output year_number,
                  output weekday, output time_changed, output date_changed,
                  input ready);
  modport sink (input valid, input seconds, input minutes, input hours,
                input day_of_month, input month_number, input year_number,
                input weekday, input time_changed, input date_changed,
                output ready);
endinterface

interface rtcc_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/core/rtcc_step.sv =====
// next-state logic: prescaler, time and calendar rollover
module rtcc_step (
  input  rtcc_pkg::rtcc_state_t  st,
  input  logic                   tick,
  input  logic [7:0]             tps,
  output rtcc_pkg::rtcc_state_t  st_nxt,
  output rtcc_pkg::rtcc_result_t res
);

  logic [7:0] pre_inc;
  logic       sec_adv;
  logic       sec_wrap;
  logic       min_wrap;
  logic       day_adv;
  logic       leap;
  logic [4:0] last_day;
  logic       month_end;
  logic       year_end;
  logic       year_inc;

  assign pre_inc   = st.prescale + 8'd1;
  assign sec_adv   = tick && (pre_inc >= tps);
  assign sec_wrap  = sec_adv && (st.sec >= rtcc_pkg::SEC_LAST);
  assign min_wrap  = sec_wrap && (st.min >= rtcc_pkg::MIN_LAST);
  assign day_adv   = min_wrap && (st.hour >= rtcc_pkg::HOUR_LAST);
  assign leap      = ((st.year[1:0] == 2'd0) && (st.year_mod100 != 7'd0))
                     || (st.year_mod400 == 9'd0);
  assign last_day  = rtcc_pkg::month_days(st.month, leap);
  assign month_end = day_adv && (st.day >= last_day);
  assign year_end  = month_end && (st.month >= rtcc_pkg::MONTH_DEC);
  assign year_inc  = year_end && (st.year < rtcc_pkg::YEAR_MAX);

  always_comb begin
    st_nxt = st;
    st_nxt.date_pending = 1'b0;
    if (tick) begin
      st_nxt.prescale = sec_adv ? 8'd0 : pre_inc;
    end
    if (sec_adv) begin
      st_nxt.sec = sec_wrap ? 6'd0 : st.sec + 6'd1;
    end
    if (sec_wrap) begin
      st_nxt.min = min_wrap ? 6'd0 : st.min + 6'd1;
    end
    if (min_wrap) begin
      st_nxt.hour = day_adv ? 5'd0 : st.hour + 5'd1;
    end
    if (day_adv) begin
      st_nxt.day  = month_end ? 5'd1 : st.day + 5'd1;
      st_nxt.week = (st.week >= rtcc_pkg::WEEK_LAST) ? 3'd1 : st.week + 3'd1;
    end
    if (month_end) begin
      st_nxt.month = year_end ? 4'd1 : st.month + 4'd1;
    end
    if (year_inc) begin
      st_nxt.year        = st.year + 14'd1;
      st_nxt.year_mod100 = (st.year_mod100 >= rtcc_pkg::MOD100_LAST) ? 7'd0
                           : st.year_mod100 + 7'd1;
      st_nxt.year_mod400 = (st.year_mod400 >= rtcc_pkg::MOD400_LAST) ? 9'd0
                           : st.year_mod400 + 9'd1;
    end
  end

  always_comb begin
    res.seconds      = st_nxt.sec;
    res.minutes      = st_nxt.min;
    res.hours        = st_nxt.hour;
    res.day_of_month = st_nxt.day;
    res.month_number = st_nxt.month;
    res.year_number  = st_nxt.year;
    res.weekday      = st_nxt.week;
    res.time_changed = sec_adv;
    res.date_changed = st.date_pending || day_adv;
  end

endmodule

// ===== rtl/core/rtc_calendar_counter.sv =====
// rtc calendar counter top level: clock and gregorian date from base ticks
// Each accepted request is one base tick (tick = 1) or a status poll (tick = 0)
// and yields exactly one result: time, date, weekday and the time/date change
// pulses. The counter state and the result register update at the accepting
// edge, and a new request is taken in every cycle as long as the result
// register is empty or being drained in the same cycle. Results are registered
// and appear in the cycle after their request. After reset the clock reads
// 12:30:00 on day 29, month 3, year 2026, weekday 7, at 20 ticks per second;
// the first result carries date_changed. ticks_per_second is written through
// the cfg channel, which is always ready; a value of 0 acts as 1.
module rtc_calendar_counter (
  input  logic       clk,
  input  logic       rst_n,
  rtcc_in_if.sink    in_ch,
  rtcc_out_if.source out_ch,
  rtcc_cfg_if.sink   cfg_ch
);

  rtcc_pkg::rtcc_state_t  state_r;
  rtcc_pkg::rtcc_state_t  state_nxt;
  rtcc_pkg::rtcc_result_t res_r;
  rtcc_pkg::rtcc_result_t res_nxt;
  logic                   out_valid_r;
  logic [7:0]             tps_r;
  logic                   in_fire;

  assign in_ch.ready  = !out_valid_r || out_ch.ready;
  assign in_fire      = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready = 1'b1;

  rtcc_step u_step (
    .st     (state_r),
    .tick   (in_ch.tick),
    .tps    (tps_r),
    .st_nxt (state_nxt),
    .res    (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= rtcc_pkg::STATE_RESET;
      out_valid_r <= 1'b0;
      tps_r       <= rtcc_pkg::TPS_RESET;
    end else begin
      if (cfg_ch.valid) begin
        tps_r <= cfg_ch.data;
      end
      if (in_fire) begin
        state_r     <= state_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      res_r <= res_nxt;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.seconds      = res_r.seconds;
  assign out_ch.minutes      = res_r.minutes;
  assign out_ch.hours        = res_r.hours;
  assign out_ch.day_of_month = res_r.day_of_month;
  assign out_ch.month_number = res_r.month_number;
  assign out_ch.year_number  = res_r.year_number;
  assign out_ch.weekday      = res_r.weekday;
  assign out_ch.time_changed = res_r.time_changed;
  assign out_ch.date_changed = res_r.date_changed;

endmodule

// ===== rtl/core/rtcc_checker.sv =====
// port-level checker for the rtc calendar counter, bound to the top level
`include "rtc_calendar_counter_macros.svh"

module rtcc_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [5:0]  seconds,
  input logic [5:0]  minutes,
  input logic [4:0]  hours,
  input logic [4:0]  day_of_month,
  input logic [3:0]  month_number,
  input logic [2:0]  weekday,
  input logic        time_changed,
  input logic        date_changed
);

  `RTCC_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid)
  `RTCC_ASSERT_NXT(a_out_stable, out_valid && !out_ready,
                   $stable(seconds) && $stable(minutes) && $stable(hours))
  `RTCC_ASSERT_IMP(a_time_range, out_valid,
                   (seconds <= 6'd59) && (minutes <= 6'd59) && (hours <= 5'd23))
  `RTCC_ASSERT_IMP(a_date_range, out_valid,
                   (month_number >= 4'd1) && (month_number <= 4'd12)
                   && (day_of_month >= 5'd1) && (weekday >= 3'd1))
  `RTCC_ASSERT_IMP(a_midnight, out_valid && date_changed && time_changed,
                   (seconds == 6'd0) && (minutes == 6'd0) && (hours == 5'd0))

endmodule

bind rtc_calendar_counter rtcc_checker u_rtcc_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .seconds      (out_ch.seconds),
  .minutes      (out_ch.minutes),
  .hours        (out_ch.hours),
  .day_of_month (out_ch.day_of_month),
  .month_number (out_ch.month_number),
  .weekday      (out_ch.weekday),
  .time_changed (out_ch.time_changed),
  .date_changed (out_ch.date_changed)
);
